// File: hdl/ssd_pkg.sv
// shared types, constants and font table for the seven-segment display controller
// used by ssd_engine and seven_segment_display_controller_core; no dependencies
package ssd_pkg;

    // default number of multiplexed digits
    localparam int DEF_NUM_DIGITS = 4;

    // fixed field widths
    localparam int CHAR_W    = 8;
    localparam int SELECT_W  = 4;
    localparam int SEGMENT_W = 8;

    // decimal point position in a segment pattern
    localparam int DP_BIT = 7;

    // font table size and the dash entry
    localparam int GLYPH_COUNT = 37;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int DIGIT_BASE  = 0;
    localparam int LETTER_BASE = 10;
    localparam int DASH_INDEX  = 36;

    // character codes the decoder cares about
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;

    // segment patterns: digits, letters a..z, dash
    localparam logic [SEGMENT_W-1:0] GLYPH_ROM [0:GLYPH_COUNT-1] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74, 8'h30, 8'h1E,
        8'h76, 8'h38, 8'h15, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h3E, 8'h1C, 8'h2A, 8'h76, 8'h6E, 8'h5B,
        8'h40
    };

    // request operation codes
    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_SCAN = 1'b1
    } t_opcode;

    // input request
    typedef struct packed {
        t_opcode           opcode;
        logic [CHAR_W-1:0] char_code;
        logic              first_char;
        logic              last_char;
    } t_in_item;

    // result
    typedef struct packed {
        logic [SELECT_W-1:0]  digit_select;
        logic [SEGMENT_W-1:0] segment_drive;
    } t_out_item;

    // character to segment pattern, blank for anything outside the font
    function automatic logic [SEGMENT_W-1:0] font_lookup(input logic [CHAR_W-1:0] ch);
        logic [SEGMENT_W-1:0] glyph;
        glyph = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            glyph = GLYPH_ROM[GLYPH_IDX_W'(ch - CH_ZERO) + GLYPH_IDX_W'(DIGIT_BASE)];
        end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            glyph = GLYPH_ROM[GLYPH_IDX_W'(ch - CH_UPPER_A) + GLYPH_IDX_W'(LETTER_BASE)];
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            glyph = GLYPH_ROM[GLYPH_IDX_W'(ch - CH_LOWER_A) + GLYPH_IDX_W'(LETTER_BASE)];
        end else if (ch == CH_DASH) begin
            glyph = GLYPH_ROM[GLYPH_IDX_W'(DASH_INDEX)];
        end
        return glyph;
    endfunction

endpackage

// File: hdl/ssd_engine.sv
// digit buffer, fill pointer and scan counter with their single-pass update logic
// depends on ssd_pkg
module ssd_engine #(
    parameter int NUM_DIGITS = ssd_pkg::DEF_NUM_DIGITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  ssd_pkg::t_in_item  i_item,
    output ssd_pkg::t_out_item o_result
);
    import ssd_pkg::*;

    localparam int FILL_W = $clog2(NUM_DIGITS + 1);
    localparam int SCAN_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [SEGMENT_W-1:0] r_pat [NUM_DIGITS];
    logic [SEGMENT_W-1:0] n_pat [NUM_DIGITS];
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [SCAN_W-1:0]    r_idx, n_idx;
    logic [SELECT_W-1:0]  r_sel, n_sel;
    logic [SEGMENT_W-1:0] r_seg, n_seg;

    logic [FILL_W-1:0]    w_fill_start;
    logic [SEGMENT_W-1:0] w_glyph;

    // font decode of the incoming character
    assign w_glyph = font_lookup(i_item.char_code);

    // a new string restarts the fill at the top digit
    assign w_fill_start = i_item.first_char ? FILL_W'(NUM_DIGITS) : r_fill;

    // next state for one request
    always_comb begin
        n_pat  = r_pat;
        n_fill = r_fill;
        n_idx  = r_idx;
        n_sel  = r_sel;
        n_seg  = r_seg;
        if (i_item.opcode == OP_SCAN) begin
            // step the multiplex counter and latch that digit's drive
            n_idx = (r_idx >= SCAN_W'(NUM_DIGITS - 1)) ? '0 : r_idx + 1'b1;
            n_sel = '0;
            for (int b = 0; b < SELECT_W; b++) begin
                if ((NUM_DIGITS - 1 - b) >= 0 && n_idx == SCAN_W'(NUM_DIGITS - 1 - b)) begin
                    n_sel[b] = 1'b1;
                end
            end
            n_seg = '0;
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (n_idx == SCAN_W'(d)) begin
                    n_seg = r_pat[d];
                end
            end
        end else begin
            n_fill = w_fill_start;
            if (w_fill_start != '0) begin
                if (i_item.char_code != CH_DOT) begin
                    // write the glyph into the next free digit
                    for (int d = 0; d < NUM_DIGITS; d++) begin
                        if (w_fill_start == FILL_W'(d + 1)) begin
                            n_pat[d] = w_glyph;
                        end
                    end
                    n_fill = w_fill_start - 1'b1;
                end else if (w_fill_start < FILL_W'(NUM_DIGITS)) begin
                    // dot goes on the digit written just before
                    for (int d = 0; d < NUM_DIGITS; d++) begin
                        if (w_fill_start == FILL_W'(d)) begin
                            n_pat[d][DP_BIT] = 1'b1;
                        end
                    end
                end
            end
            // end of string blanks what is still free and closes it
            if (i_item.last_char) begin
                for (int d = 0; d < NUM_DIGITS; d++) begin
                    if (FILL_W'(d) < n_fill) begin
                        n_pat[d] = '0;
                    end
                end
                n_fill = '0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                r_pat[d] <= '0;
            end
            r_fill <= '0;
            r_idx  <= '0;
            r_sel  <= '0;
            r_seg  <= '0;
        end else if (i_step) begin
            r_pat  <= n_pat;
            r_fill <= n_fill;
            r_idx  <= n_idx;
            r_sel  <= n_sel;
            r_seg  <= n_seg;
        end
    end

    // result is the drive held after this request
    assign o_result.digit_select  = n_sel;
    assign o_result.segment_drive = n_seg;

endmodule

// File: hdl/seven_segment_display_controller_core.sv
// Multiplexed seven-segment display controller, top level.
// Requests enter on the in channel (valid/ready, t_in_item) and each one gives
// exactly one result on the out channel (valid/ready, t_out_item).
// A character request fills the digit buffer from the top digit down; a scan
// request steps the multiplex counter and returns the one-hot digit select and
// that digit's segments. A character request returns the drive currently held.
// A request accepted into the input register moves through the engine's update
// into the result register, which drives o_out_item, once the result slot is
// free or draining.
// Throughput: one request per cycle while results are taken, set by the single
// input and result registers; the state update is one level of shallow logic.
// The input register takes a new request while a result waits to be taken, as
// long as it is empty or the result register can move on in the same cycle.
// When the receiver stalls, the result holds, the pending request waits in the
// input register and o_in_ready drops once both are occupied.
// Reset (synchronous, active low) blanks the digit buffer, closes any open
// string, clears the scan counter and the held drive, and empties both stages.
// depends on ssd_pkg and ssd_engine
module seven_segment_display_controller_core #(
    parameter int NUM_DIGITS = ssd_pkg::DEF_NUM_DIGITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ssd_pkg::t_out_item o_out_item
);
    import ssd_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      w_advance;
    t_out_item w_result;

    // request moves into the engine when the result slot is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // buffer, fill and scan state
    ssd_engine #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
